@@ rtl/core/sdd_pkg.sv @@
// ----------------------------------------------------------------------------
// sdd_pkg
// Shared types and constants of the scaled DAC debug output block.
// ----------------------------------------------------------------------------
`default_nettype none

package sdd_pkg;

  // Configuration port geometry.
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  // Field widths.
  localparam int unsigned SampleW = 32;
  localparam int unsigned CodeW   = 8;
  localparam int unsigned WordW   = 16;
  localparam int unsigned DivW    = 16;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 24;

  // Largest DAC code.
  localparam logic [CodeW-1:0] CodeMax = 8'hFF;

  // Register indexes of the configuration port.
  typedef enum logic [CfgAddrW-1:0] {
    REG_MIN_VALUE   = 3'd0,
    REG_MAX_VALUE   = 3'd1,
    REG_GAIN        = 3'd2,
    REG_UPDATE_DIV  = 3'd3,
    REG_DAC_CHANNEL = 3'd4,
    REG_RANGE_BIT   = 3'd5,
    REG_ENABLE      = 3'd6
  } sdd_reg_idx_t;

  // Register file contents as seen by the datapath.
  typedef struct packed {
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic        [31:0] gain;
    logic   [DivW-1:0]  update_div;
    logic        [1:0]  dac_channel;
    logic               range_bit;
    logic               enable;
  } sdd_cfg_t;

  // Reset values of the registers.
  localparam logic signed [31:0] MinValueRst   = 32'sd0;
  localparam logic signed [31:0] MaxValueRst   = 32'sd65536;
  localparam logic        [31:0] GainRst       = 32'd16711680;
  localparam logic   [DivW-1:0]  UpdateDivRst  = 16'd1;

endpackage : sdd_pkg

`default_nettype wire

@@ rtl/core/scaled_dac_debug_output_top.sv @@
// ----------------------------------------------------------------------------
// scaled_dac_debug_output_top
// Scales signed Q16.16 samples to 8-bit DAC codes and emits one DAC control
// word every update_div enabled samples, or every one for a divider of zero.
// ----------------------------------------------------------------------------
// The block takes one sample beat per clock unless the output stalls it, and
// has three register stages (input and prescaler, multiply, round and pack).
// Only every update_div-th enabled sample produces an output beat (a divider
// of zero acts as one); samples taken while disabled are dropped and do not
// advance the prescaler. Throughput is set by the single 32x32 multiplier
// stage and is one sample per cycle as long as out_tready is high.
// Registers are written through the cfg port and must only change while no
// sample is in flight.
`default_nettype none

module scaled_dac_debug_output_top
  import sdd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Configuration write port.
  input  wire logic                cfg_we,
  input  wire logic [CfgAddrW-1:0] cfg_addr,
  input  wire logic [CfgDataW-1:0] cfg_wdata,
  // Sample stream.
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [InDataW-1:0]  in_tdata,   // [31:0] sample
  // DAC word stream.
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OutDataW-1:0]      out_tdata   // [15:0] control_word, [23:16] code
);

  sdd_cfg_t             cfg;
  logic                 s1_valid, s1_ready;
  logic [SampleW-1:0]   s1_sample;
  logic                 s2_valid, s2_ready;
  logic [2*SampleW-1:0] s2_prod;
  logic                 s2_zero, s2_full;
  logic [WordW-1:0]     out_word;
  logic [CodeW-1:0]     out_code;

  sdd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  sdd_decim u_decim (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_i     (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (in_tdata[SampleW-1:0]),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1_sample (s1_sample)
  );

  sdd_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_i     (cfg),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1_sample (s1_sample),
    .s2_valid  (s2_valid),
    .s2_ready  (s2_ready),
    .s2_prod   (s2_prod),
    .s2_zero   (s2_zero),
    .s2_full   (s2_full)
  );

  sdd_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_i     (cfg),
    .s2_valid  (s2_valid),
    .s2_ready  (s2_ready),
    .s2_prod   (s2_prod),
    .s2_zero   (s2_zero),
    .s2_full   (s2_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (out_word),
    .out_code  (out_code)
  );

  assign out_tdata = {out_code, out_word};

  // A beat taken while disabled never enters the pipeline.
  a_disabled_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !cfg.enable) |=> !s1_valid)
    else $error("disabled sample entered the pipeline");

  // With a divider of one every enabled beat emits.
  a_div_one_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && cfg.enable && (cfg.update_div == DivW'(1))) |=> s1_valid)
    else $error("enabled sample dropped with divider of one");

  // A stalled first stage keeps its sample.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !s1_ready) |=> (s1_valid && $stable(s1_sample)))
    else $error("first stage lost its sample under stall");

  // The word carries the code and the low five bits stay clear.
  a_word_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[4:0] == 5'b00000) && (out_tdata[12:5] == out_tdata[23:16])))
    else $error("control word does not match code");

endmodule : scaled_dac_debug_output_top

`default_nettype wire

@@ rtl/core/sdd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// sdd_cfg_regs
// Write-only configuration registers of the scaled DAC debug output block.
// ----------------------------------------------------------------------------
`default_nettype none

module sdd_cfg_regs
  import sdd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CfgAddrW-1:0] cfg_addr,
  input  wire logic [CfgDataW-1:0] cfg_wdata,
  output sdd_cfg_t                 cfg_o
);

  sdd_cfg_t cfg_r;
  sdd_cfg_t cfg_nxt;

  // Decode the write; an unused index leaves everything as it is.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (sdd_reg_idx_t'(cfg_addr))
        REG_MIN_VALUE:   cfg_nxt.min_value   = $signed(cfg_wdata);
        REG_MAX_VALUE:   cfg_nxt.max_value   = $signed(cfg_wdata);
        REG_GAIN:        cfg_nxt.gain        = cfg_wdata;
        REG_UPDATE_DIV:  cfg_nxt.update_div  = cfg_wdata[DivW-1:0];
        REG_DAC_CHANNEL: cfg_nxt.dac_channel = cfg_wdata[1:0];
        REG_RANGE_BIT:   cfg_nxt.range_bit   = cfg_wdata[0];
        REG_ENABLE:      cfg_nxt.enable      = cfg_wdata[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_value   <= MinValueRst;
      cfg_r.max_value   <= MaxValueRst;
      cfg_r.gain        <= GainRst;
      cfg_r.update_div  <= UpdateDivRst;
      cfg_r.dac_channel <= 2'd0;
      cfg_r.range_bit   <= 1'b0;
      cfg_r.enable      <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule : sdd_cfg_regs

`default_nettype wire

@@ rtl/core/sdd_decim.sv @@
// ----------------------------------------------------------------------------
// sdd_decim
// Input register and sample prescaler; only beats that emit a word go on.
// ----------------------------------------------------------------------------
`default_nettype none

module sdd_decim
  import sdd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sdd_cfg_t           cfg_i,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [SampleW-1:0] in_sample,
  output logic                    s1_valid,
  input  wire logic               s1_ready,
  output logic      [SampleW-1:0] s1_sample
);

  logic [DivW-1:0]    cnt_r, cnt_nxt;
  logic               valid_r, valid_nxt;
  logic [SampleW-1:0] sample_r;
  logic [DivW-1:0]    cnt_inc;
  logic               emit;
  logic               acc;

  assign in_ready = !valid_r || s1_ready;
  assign acc      = in_valid && in_ready;

  // Prescaler: count each enabled sample, emit when the count reaches or passes the divider.
  assign cnt_inc = cnt_r + DivW'(1);
  assign emit    = (cnt_inc >= cfg_i.update_div);

  always_comb begin
    cnt_nxt   = cnt_r;
    valid_nxt = valid_r;
    if (acc) begin
      valid_nxt = cfg_i.enable && emit;
      if (cfg_i.enable) begin
        cnt_nxt = emit ? '0 : cnt_inc;
      end
    end else if (s1_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Sample holding register.
  always_ff @(posedge clk) begin
    if (acc) begin
      sample_r <= in_sample;
    end
  end

  assign s1_valid  = valid_r;
  assign s1_sample = sample_r;

endmodule : sdd_decim

`default_nettype wire

@@ rtl/core/sdd_mul.sv @@
// ----------------------------------------------------------------------------
// sdd_mul
// Range test and offset-times-gain product, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sdd_mul
  import sdd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sdd_cfg_t           cfg_i,
  input  wire logic               s1_valid,
  output logic                    s1_ready,
  input  wire logic [SampleW-1:0] s1_sample,
  output logic                    s2_valid,
  input  wire logic               s2_ready,
  output logic [2*SampleW-1:0]    s2_prod,
  output logic                    s2_zero,
  output logic                    s2_full
);

  logic                      valid_r, valid_nxt;
  logic [2*SampleW-1:0]      prod_r;
  logic                      zero_r, full_r;
  logic signed [SampleW-1:0] smp;
  logic [SampleW-1:0]        diff_w;
  logic [2*SampleW-1:0]      prod_w;
  logic                      take;

  assign s1_ready = !valid_r || s2_ready;
  assign take     = s1_valid && s1_ready;
  assign smp      = $signed(s1_sample);

  // Offset from the minimum; exact and below 2^32 whenever the linear case applies.
  assign diff_w = s1_sample - cfg_i.min_value;
  assign prod_w = diff_w * cfg_i.gain;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (s2_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Both range tests are registered with the product; sdd_out gives the minimum test priority.
  always_ff @(posedge clk) begin
    if (take) begin
      prod_r <= prod_w;
      zero_r <= (smp <= cfg_i.min_value);
      full_r <= (smp >= cfg_i.max_value);
    end
  end

  assign s2_valid = valid_r;
  assign s2_prod  = prod_r;
  assign s2_zero  = zero_r;
  assign s2_full  = full_r;

endmodule : sdd_mul

`default_nettype wire

@@ rtl/core/sdd_out.sv @@
// ----------------------------------------------------------------------------
// sdd_out
// Rounding, saturation, control word packing and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sdd_out
  import sdd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sdd_cfg_t             cfg_i,
  input  wire logic                 s2_valid,
  output logic                      s2_ready,
  input  wire logic [2*SampleW-1:0] s2_prod,
  input  wire logic                 s2_zero,
  input  wire logic                 s2_full,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [WordW-1:0]          out_word,
  output logic [CodeW-1:0]          out_code
);

  logic               valid_r, valid_nxt;
  logic [WordW-1:0]   word_r;
  logic [CodeW-1:0]   code_r;
  logic [SampleW:0]   rnd;
  logic [CodeW-1:0]   code_w;
  logic               take;

  assign s2_ready = !valid_r || out_ready;
  assign take     = s2_valid && s2_ready;

  // Add one half and keep the integer part of the Q32.32 product.
  assign rnd = {1'b0, s2_prod[2*SampleW-1:SampleW]} + (SampleW+1)'(s2_prod[SampleW-1]);

  always_comb begin
    if (s2_zero) begin
      code_w = '0;
    end else if (s2_full || (rnd[SampleW:CodeW] != '0)) begin
      code_w = CodeMax;
    end else begin
      code_w = rnd[CodeW-1:0];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Control word: channel, range select, code, five zero bits.
  always_ff @(posedge clk) begin
    if (take) begin
      code_r <= code_w;
      word_r <= {cfg_i.dac_channel, cfg_i.range_bit, code_w, 5'b00000};
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;
  assign out_code  = code_r;

endmodule : sdd_out

`default_nettype wire

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the scaled DAC debug output block.
// ----------------------------------------------------------------------------
// Samples are driven as beats on the input stream. Every accepted beat is run
// through a local copy of the scaler and prescaler, and the DAC word it should
// produce is queued. Each output beat is compared field by field with the
// oldest queued word. Registers change only while the block is idle. Directed
// tests cover the range ends, the saturation and degenerate-span cases and the
// divider corner cases. Random phases then run with varied register settings
// and random idle and stall cycles on both streams.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sdd_pkg::*;

  // Cycles to let pass after the last expected beat. This covers the
  // three-stage pipeline, with margin.
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned RandomPhases = 10;
  localparam int unsigned PhaseSamples = 100;
  // An index that maps to no register. Writes to it must be ignored.
  localparam logic [CfgAddrW-1:0] RegOutOfRange = 3'd7;

  typedef struct {
    logic [WordW-1:0] word;
    logic [CodeW-1:0] code;
  } dac_beat_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;   // [31:0] sample
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;  // [15:0] control_word, [23:16] code

  // Local copy of the register file and the prescaler.
  sdd_cfg_t        dac_cfg;
  logic [DivW-1:0] prescale_count;
  dac_beat_t       expected_beats[$];

  int unsigned mismatch_count;
  int unsigned in_gap_max;
  int unsigned out_stall_max;

  scaled_dac_debug_output_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock generation.
  always #6 clk = ~clk;

  // Prints one mismatch line and counts it.
  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] seen);
    $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, seen);
    mismatch_count++;
  endtask

  // Rounded, saturated DAC code of one Q16.16 sample.
  function automatic logic [CodeW-1:0] scale_to_code(input logic signed [31:0] smp);
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [32:0] span;
    logic [63:0]        prod;
    lo = dac_cfg.min_value;
    hi = dac_cfg.max_value;
    if (smp <= lo) return '0;
    if (smp >= hi) return CodeMax;
    // The span is positive and below 2^32 here, so the Q32.32 product is exact.
    span = 33'(smp) - 33'(lo);
    prod = {32'd0, span[31:0]} * {32'd0, dac_cfg.gain} + 64'h0000_0000_8000_0000;
    if (prod[63:32] > 32'(CodeMax)) return CodeMax;
    return prod[39:32];
  endfunction

  // Advances the prescaler for one accepted enabled sample and queues its word if due.
  function automatic void predict_sample(input logic [InDataW-1:0] smp);
    dac_beat_t beat;
    if (!dac_cfg.enable) return;
    beat.code = scale_to_code(smp);
    prescale_count = prescale_count + 1'b1;
    if (prescale_count >= dac_cfg.update_div) begin
      prescale_count = '0;
      beat.word = {dac_cfg.dac_channel, dac_cfg.range_bit, beat.code, 5'b00000};
      expected_beats.push_back(beat);
    end
  endfunction

  // Mirrors one register write into the local register copy.
  function automatic void apply_cfg(input logic [CfgAddrW-1:0] idx,
                                    input logic [CfgDataW-1:0] val);
    case (idx)
      REG_MIN_VALUE:   dac_cfg.min_value   = val;
      REG_MAX_VALUE:   dac_cfg.max_value   = val;
      REG_GAIN:        dac_cfg.gain        = val;
      REG_UPDATE_DIV:  dac_cfg.update_div  = val[DivW-1:0];
      REG_DAC_CHANNEL: dac_cfg.dac_channel = val[1:0];
      REG_RANGE_BIT:   dac_cfg.range_bit   = val[0];
      REG_ENABLE:      dac_cfg.enable      = val[0];
      default: ;
    endcase
  endfunction

  // Writes one register. Only called while the block is idle.
  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_cfg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_scale(input logic [31:0] lo, input logic [31:0] hi,
                           input logic [31:0] gain_val);
    write_reg(REG_MIN_VALUE, lo);
    write_reg(REG_MAX_VALUE, hi);
    write_reg(REG_GAIN, gain_val);
  endtask

  // Sends one sample beat after a random number of idle cycles.
  // The valid stays high across back-to-back beats.
  task automatic send_sample(input logic [31:0] smp);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    do @(posedge clk); while (in_tready !== 1'b1);
  endtask

  // Idles the input and waits until every queued word has been checked and
  // the pipeline has emptied.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Sample near the programmed range, or anywhere at all now and then.
  function automatic logic [31:0] pick_sample(input longint lim_a, input longint lim_b);
    longint a;
    longint b;
    longint s;
    if ($urandom_range(0, 4) == 0) return $urandom();
    a = (lim_a < lim_b) ? lim_a : lim_b;
    b = (lim_a < lim_b) ? lim_b : lim_a;
    s = a - 2 + longint'($urandom()) % (b - a + 5);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  // Samples sent while disabled are dropped and do not count.
  task automatic test_disabled_drop();
    send_sample(32'h0000_8000);
    send_sample(32'h7FFF_FFFF);
    settle();
    write_reg(REG_ENABLE, 32'h0000_0001);
  endtask

  // Reset scaling: zero to one unit maps to 0..255.
  task automatic test_unit_span();
    send_sample(32'h0000_0000);
    send_sample(32'h0001_0000);
    send_sample(32'h0000_8000);
    send_sample(32'h0000_0001);
    send_sample(32'h0000_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    settle();
  endtask

  // Full signed range with the top channel and range bit set.
  task automatic test_full_span();
    set_scale(32'h8000_0000, 32'h7FFF_FFFF, 32'd255);
    write_reg(REG_DAC_CHANNEL, 32'h0000_0003);
    write_reg(REG_RANGE_BIT, 32'h0000_0001);
    send_sample(32'h8000_0001);
    send_sample(32'h0000_0000);
    send_sample(32'h7FFF_FFFE);
    send_sample(32'hFF80_0000);
    settle();
  endtask

  // Minimum equal to, then above, the maximum.
  task automatic test_degenerate_span();
    set_scale(32'h0000_0100, 32'h0000_0100, 32'd255);
    send_sample(32'h0000_0100);
    send_sample(32'h0000_0101);
    send_sample(32'h0000_00FF);
    settle();
    set_scale(32'd1000, -32'sd1000, 32'd255);
    send_sample(32'h0000_0000);
    send_sample(32'd2000);
    settle();
  endtask

  // Largest gain saturates the linear result; zero gain flattens it.
  task automatic test_gain_extremes();
    set_scale(32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_sample(32'h0000_0001);
    send_sample(32'h0001_0000);
    settle();
    write_reg(REG_GAIN, 32'h0000_0000);
    send_sample(32'h4000_0000);
    settle();
    set_scale(32'hFFFF_0000, 32'h0001_0000, 32'h007F_8000);
  endtask

  // Divider of zero, a typical divider, the largest one lowered mid-count,
  // a write to an unused index, and a disabled stretch.
  task automatic test_decimation();
    write_reg(REG_UPDATE_DIV, 32'h0000_0000);
    send_sample(32'hFFFF_8000);
    send_sample(32'h0000_8000);
    settle();
    write_reg(REG_UPDATE_DIV, 32'hABCD_0003);
    repeat (4) send_sample($urandom());
    settle();
    write_reg(REG_UPDATE_DIV, 32'h0000_FFFF);
    send_sample(32'h0000_4000);
    send_sample(32'hFFFF_C000);
    settle();
    write_reg(REG_UPDATE_DIV, 32'h0000_0002);
    write_reg(RegOutOfRange, 32'hFFFF_FFFF);
    send_sample(32'h0000_C000);
    settle();
    write_reg(REG_ENABLE, 32'h0000_0000);
    send_sample(32'h0000_2000);
    settle();
    write_reg(REG_ENABLE, 32'hFFFF_FFFF);
    send_sample(32'h0000_6000);
    send_sample(32'h0000_A000);
    settle();
  endtask

  // Random register settings per phase, then random samples around the range.
  task automatic test_random_phases();
    longint      lo;
    longint      hi;
    longint      gain_calc;
    logic [31:0] gain_val;
    logic [15:0] div_val;
    logic        en;
    int unsigned pick;
    for (int p = 0; p < RandomPhases; p++) begin
      // Some phases run with no idling on either stream.
      in_gap_max    = (p % 4 == 3) ? 0 : 5;
      out_stall_max = (p % 4 == 3) ? 0 : 5;

      // Mostly well-ordered spans, some narrow, some in either order.
      lo   = longint'(int'($urandom()));
      hi   = longint'(int'($urandom()));
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        if (lo > hi) begin
          gain_calc = lo;
          lo = hi;
          hi = gain_calc;
        end
      end else if (pick < 8) begin
        hi = lo + $urandom_range(1, 1 << 20);
        if (hi > 64'sd2147483647) hi = 64'sd2147483647;
      end

      // Matching gain most of the time, otherwise random or extreme.
      gain_calc = (hi > lo) ? ((64'sd255 <<< 32) / (hi - lo)) : 64'sd255;
      if (gain_calc > 64'sh0_FFFF_FFFF) gain_calc = 64'sh0_FFFF_FFFF;
      case ($urandom_range(0, 9))
        7:       gain_val = $urandom();
        8:       gain_val = 32'h0000_0000;
        9:       gain_val = 32'hFFFF_FFFF;
        default: gain_val = gain_calc[31:0];
      endcase

      case ($urandom_range(0, 9))
        0:       div_val = 16'd0;
        1:       div_val = 16'($urandom_range(5, 65535));
        default: div_val = 16'($urandom_range(1, 4));
      endcase
      en = ($urandom_range(0, 9) != 0);

      set_scale(lo[31:0], hi[31:0], gain_val);
      write_reg(REG_UPDATE_DIV, ($urandom() & 32'hFFFF_0000) | {16'd0, div_val});
      write_reg(REG_DAC_CHANNEL, $urandom());
      write_reg(REG_RANGE_BIT, $urandom());
      write_reg(REG_ENABLE, ($urandom() & 32'hFFFF_FFFE) | {31'd0, en});

      repeat (PhaseSamples) send_sample(pick_sample(lo, hi));
      settle();
    end
  endtask

  // Predict every accepted sample beat.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) predict_sample(in_tdata);
  end

  // Compare every accepted output beat with the oldest expected word.
  always @(posedge clk) begin
    dac_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_beats.size() == 0) begin
        flag_mismatch("unexpected beat", 32'd0, {8'd0, out_tdata});
      end else begin
        want = expected_beats.pop_front();
        if (out_tdata[15:0] !== want.word)
          flag_mismatch("control_word", {16'd0, want.word}, {16'd0, out_tdata[15:0]});
        if (out_tdata[23:16] !== want.code)
          flag_mismatch("code", {24'd0, want.code}, {24'd0, out_tdata[23:16]});
      end
    end
  end

  // Output side: a random stall before each beat is taken.
  initial begin
    int unsigned stall;
    out_tready = 1'b0;
    forever begin
      stall = $urandom_range(0, out_stall_max);
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  // Main sequence.
  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_addr       = '0;
    cfg_wdata      = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    mismatch_count = 0;
    in_gap_max     = 5;
    out_stall_max  = 5;
    prescale_count = '0;
    dac_cfg        = '{min_value: MinValueRst, max_value: MaxValueRst, gain: GainRst,
                       update_div: UpdateDivRst, dac_channel: 2'd0, range_bit: 1'b0,
                       enable: 1'b0};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_disabled_drop();
    test_unit_span();
    test_full_span();
    test_degenerate_span();
    test_gain_extremes();
    test_decimation();
    test_random_phases();

    settle();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule : tb_top

`default_nettype wire

@@ scaled_dac_debug_output_top.f @@
rtl/core/sdd_pkg.sv
rtl/core/sdd_cfg_regs.sv
rtl/core/sdd_decim.sv
rtl/core/sdd_mul.sv
rtl/core/sdd_out.sv
rtl/core/scaled_dac_debug_output_top.sv
bench/tb_top.sv
